/* sv/bmmar_pkg.sv */
// Package for the brick min/max/average reducer.
// Holds the beat types, the controller/datapath command structs and the
// sample decode/encode helpers. Depends on nothing.
package bmmar_pkg;

  // Component ports on each voxel beat
  localparam int NUM_COMP_PORTS = 4;
  // Steps of the restoring divider (one quotient bit per step)
  localparam int DIV_STEPS = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BRICK_EDGE      = 2'd0;
  localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
  localparam logic [1:0] REG_SAMPLE_TYPE     = 2'd2;

  // Sample type codes
  localparam logic [1:0] ST_U8  = 2'd0;
  localparam logic [1:0] ST_S8  = 2'd1;
  localparam logic [1:0] ST_U16 = 2'd2;
  localparam logic [1:0] ST_S16 = 2'd3;

  typedef struct packed {
    logic [15:0] comp0;
    logic [15:0] comp1;
    logic [15:0] comp2;
    logic [15:0] comp3;
  } voxel_t;

  typedef struct packed {
    logic        nonuniform;
    logic [15:0] level0;
    logic [15:0] level1;
    logic [15:0] level2;
    logic [15:0] level3;
    logic [15:0] brick_number;
  } result_t;

  // Effective configuration as seen by controller and datapath
  typedef struct packed {
    logic [2:0]  comps;
    logic [1:0]  stype;
    logic [15:0] total;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        accept;
    logic        first;
    logic        last;
    logic [15:0] taken;
    logic        load;
    logic        step;
    logic        finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic result_busy;
  } dp_status_t;

  // Interpret raw bits under the sample type, widened to 17-bit signed
  function automatic logic signed [16:0] decode_sample(logic [15:0] raw, logic [1:0] st);
    logic signed [16:0] v;
    case (st)
      ST_U8:   v = {9'd0, raw[7:0]};
      ST_S8:   v = {{9{raw[7]}}, raw[7:0]};
      ST_U16:  v = {1'b0, raw};
      default: v = {raw[15], raw};
    endcase
    return v;
  endfunction

  // Raw bits of a level value under the sample type
  function automatic logic [15:0] encode_level(logic [15:0] v, logic [1:0] st);
    logic [15:0] r;
    if (st == ST_U8 || st == ST_S8) begin
      r = {8'd0, v[7:0]};
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/bmmar_regs.sv */
// Configuration register file on the APB-style port.
// Produces the clamped component count, sample type and voxels per brick.
// Depends on bmmar_pkg.
module bmmar_regs #(
  parameter int MAX_COMPONENTS = 4,
  parameter int MAX_EDGE       = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bmmar_pkg::cfg_t     cfg
);

  localparam int LANES = (MAX_COMPONENTS < bmmar_pkg::NUM_COMP_PORTS) ?
                         MAX_COMPONENTS : bmmar_pkg::NUM_COMP_PORTS;

  logic [5:0]  brick_edge;
  logic [2:0]  component_count;
  logic [1:0]  sample_type;
  logic        wr_en;
  logic [5:0]  edge_eff;
  logic [11:0] edge_sq;
  logic [17:0] edge_cube;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      brick_edge      <= 6'd16;
      component_count <= 3'd1;
      sample_type     <= bmmar_pkg::ST_U16;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        bmmar_pkg::REG_BRICK_EDGE:      brick_edge      <= pwdata[5:0];
        bmmar_pkg::REG_COMPONENT_COUNT: component_count <= pwdata[2:0];
        bmmar_pkg::REG_SAMPLE_TYPE:     sample_type     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      bmmar_pkg::REG_BRICK_EDGE:      prdata = {26'd0, brick_edge};
      bmmar_pkg::REG_COMPONENT_COUNT: prdata = {29'd0, component_count};
      bmmar_pkg::REG_SAMPLE_TYPE:     prdata = {30'd0, sample_type};
      default:                        prdata = 32'd0;
    endcase
  end

  // Clamp edge and cube it
  always_comb begin
    if (brick_edge == 6'd0) begin
      edge_eff = 6'd1;
    end else if (brick_edge > 6'(MAX_EDGE)) begin
      edge_eff = 6'(MAX_EDGE);
    end else begin
      edge_eff = brick_edge;
    end
    edge_sq   = {6'd0, edge_eff} * {6'd0, edge_eff};
    edge_cube = {6'd0, edge_sq} * {12'd0, edge_eff};
  end

  // Clamp component count to the built lanes
  always_comb begin
    if (component_count == 3'd0) begin
      cfg.comps = 3'd1;
    end else if (component_count > 3'(LANES)) begin
      cfg.comps = 3'(LANES);
    end else begin
      cfg.comps = component_count;
    end
    cfg.stype = sample_type;
    cfg.total = edge_cube[15:0];
  end

endmodule

/* sv/bmmar_ctrl.sv */
// Controller for the brick reducer: voxel counting, brick end detection
// and sequencing of the divide and result load. Depends on bmmar_pkg.
module bmmar_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   voxel_valid,
  output logic                   voxel_ready,
  input  bmmar_pkg::cfg_t        cfg,
  input  bmmar_pkg::dp_status_t  status,
  output bmmar_pkg::ctrl_cmd_t   cmd
);

  localparam int STEP_W = $clog2(bmmar_pkg::DIV_STEPS);

  typedef enum logic [1:0] {S_RUN, S_LOAD, S_DIV, S_FIN} state_t;

  state_t              state;
  logic [15:0]         voxel_count;
  logic [STEP_W-1:0]   step_cnt;
  logic [16:0]         taken_w;

  assign voxel_ready = (state == S_RUN);
  assign taken_w     = {1'b0, voxel_count} + 17'd1;

  // Decode commands from state
  always_comb begin
    cmd.accept = (state == S_RUN) && voxel_valid;
    cmd.first  = (voxel_count == 16'd0);
    cmd.taken  = taken_w[15:0];
    cmd.last   = (taken_w >= {1'b0, cfg.total});
    cmd.load   = (state == S_LOAD);
    cmd.step   = (state == S_DIV);
    cmd.finish = (state == S_FIN) && !status.result_busy;
  end

  // Advance state, voxel counter and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      voxel_count <= 16'd0;
      step_cnt    <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (cmd.accept) begin
            if (cmd.last) begin
              voxel_count <= 16'd0;
              state       <= S_LOAD;
            end else begin
              voxel_count <= taken_w[15:0];
            end
          end
        end
        S_LOAD: begin
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(bmmar_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd.finish) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

/* sv/bmmar_dp.sv */
// Datapath for the brick reducer: per-lane min/max/sum accumulators,
// per-lane restoring dividers and the result register. Depends on bmmar_pkg.
module bmmar_dp #(
  parameter int MAX_COMPONENTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bmmar_pkg::voxel_t      voxel,
  input  bmmar_pkg::cfg_t        cfg,
  input  bmmar_pkg::ctrl_cmd_t   cmd,
  output bmmar_pkg::dp_status_t  status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output bmmar_pkg::result_t     result
);

  localparam int LANES = (MAX_COMPONENTS < bmmar_pkg::NUM_COMP_PORTS) ?
                         MAX_COMPONENTS : bmmar_pkg::NUM_COMP_PORTS;

  logic [15:0]        raw [bmmar_pkg::NUM_COMP_PORTS];
  logic signed [16:0] samp [LANES];
  logic               lane_en [LANES];
  logic signed [16:0] cmin [LANES];
  logic signed [16:0] cmax [LANES];
  logic signed [31:0] csum [LANES];
  logic [16:0]        rem [LANES];
  logic [31:0]        quo [LANES];
  logic               neg [LANES];
  logic [15:0]        divisor;
  logic               nonuni;
  logic               nonuni_next;
  logic [15:0]        brick_count;
  logic [15:0]        lvl [bmmar_pkg::NUM_COMP_PORTS];

  assign raw[0] = voxel.comp0;
  assign raw[1] = voxel.comp1;
  assign raw[2] = voxel.comp2;
  assign raw[3] = voxel.comp3;

  assign status.result_busy = result_valid && !result_ready;

  // Decode samples and lane enables
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      samp[j]    = bmmar_pkg::decode_sample(raw[j], cfg.stype);
      lane_en[j] = (3'(j) < cfg.comps);
    end
  end

  // Any lane in use whose min and max differ
  always_comb begin
    nonuni_next = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      if (lane_en[j] && (cmin[j] != cmax[j])) begin
        nonuni_next = 1'b1;
      end
    end
  end

  // Accumulate, then load and step the dividers
  always_ff @(posedge clk) begin
    logic [16:0] trial;
    logic [31:0] mag;
    if (cmd.accept && cmd.last) begin
      divisor <= cmd.taken;
    end
    if (cmd.load) begin
      nonuni <= nonuni_next;
    end
    for (int j = 0; j < LANES; j++) begin
      trial = {rem[j][15:0], quo[j][31]};
      mag   = csum[j][31] ? (~csum[j] + 32'd1) : csum[j];
      if (cmd.accept && lane_en[j]) begin
        if (cmd.first) begin
          cmin[j] <= samp[j];
          cmax[j] <= samp[j];
          csum[j] <= 32'(samp[j]);
        end else begin
          if (samp[j] < cmin[j]) cmin[j] <= samp[j];
          if (samp[j] > cmax[j]) cmax[j] <= samp[j];
          csum[j] <= csum[j] + 32'(samp[j]);
        end
      end
      if (cmd.load) begin
        rem[j] <= 17'd0;
        quo[j] <= mag;
        neg[j] <= csum[j][31];
      end else if (cmd.step) begin
        if (trial >= {1'b0, divisor}) begin
          rem[j] <= trial - {1'b0, divisor};
          quo[j] <= {quo[j][30:0], 1'b1};
        end else begin
          rem[j] <= trial;
          quo[j] <= {quo[j][30:0], 1'b0};
        end
      end
    end
  end

  // Pick each level: uniform value, signed mean, or zero for unused lanes
  always_comb begin
    logic [31:0] q;
    for (int j = 0; j < bmmar_pkg::NUM_COMP_PORTS; j++) begin
      lvl[j] = 16'd0;
    end
    for (int j = 0; j < LANES; j++) begin
      q = neg[j] ? (~quo[j] + 32'd1) : quo[j];
      if (lane_en[j]) begin
        if (nonuni) begin
          lvl[j] = bmmar_pkg::encode_level(q[15:0], cfg.stype);
        end else begin
          lvl[j] = bmmar_pkg::encode_level(cmin[j][15:0], cfg.stype);
        end
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.nonuniform   <= nonuni;
      result.level0       <= lvl[0];
      result.level1       <= lvl[1];
      result.level2       <= lvl[2];
      result.level3       <= lvl[3];
      result.brick_number <= brick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      brick_count  <= 16'd0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
      brick_count  <= brick_count + 16'd1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

/* sv/brick_min_max_average_reducer.sv */
// Brick min/max/average reducer. Voxel beats are taken one per cycle while a
// brick fills; per component the block tracks minimum, maximum and sum. On the
// brick's last voxel it latches the sums (S_LOAD), runs the per-lane restoring
// dividers (S_DIV, one quotient bit per cycle) and loads the result register
// (S_FIN); voxel_ready stays low during that tail, and longer if the previous
// result beat has not been taken. The result register frees the input side as
// soon as it is loaded.
// Depends on bmmar_pkg, bmmar_regs, bmmar_ctrl, bmmar_dp.
module brick_min_max_average_reducer #(
  parameter int MAX_COMPONENTS = 4,
  parameter int MAX_EDGE       = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 voxel_valid,
  output logic                 voxel_ready,
  input  bmmar_pkg::voxel_t    voxel,
  output logic                 result_valid,
  input  logic                 result_ready,
  output bmmar_pkg::result_t   result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  bmmar_pkg::cfg_t        cfg;
  bmmar_pkg::ctrl_cmd_t   cmd;
  bmmar_pkg::dp_status_t  status;

  bmmar_regs #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_EDGE       (MAX_EDGE)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmmar_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .cfg         (cfg),
    .status      (status),
    .cmd         (cmd)
  );

  bmmar_dp #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .voxel        (voxel),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* sv/bmmar_checker.sv */
// Port-level checks for the brick reducer, bound to the top level.
// Depends on bmmar_pkg and brick_min_max_average_reducer.
module bmmar_checker (
  input logic                clk,
  input logic                rst,
  input logic                voxel_ready,
  input logic                result_valid,
  input logic                result_ready,
  input bmmar_pkg::result_t  result,
  input logic                pready
);

  // Reset drops any pending result beat
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // Handshake outputs stay known and the configuration port never waits
  assert property (@(posedge clk) disable iff (rst)
    pready && !$isunknown({voxel_ready, result_valid}))
    else $error("handshake output unknown or pready low");

  // The result register loads only while voxel intake is stopped
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!voxel_ready))
    else $error("result appeared while voxels were being taken");

endmodule

bind brick_min_max_average_reducer bmmar_checker u_bmmar_checker (.*);
